>>> rtl/cbmvm_pkg.sv
`default_nettype none
package cbmvm_pkg;

  // Default geometry
  localparam int LANES_DEF = 8;
  localparam int ACC_W_DEF = 48;

  // Fixed field widths
  localparam int COEF_W       = 16;
  localparam int SMP_W        = 16;
  localparam int CAS_W        = 48;
  localparam int OUT_W        = 16;
  localparam int SHIFT_W      = 6;
  localparam int IDX_W        = 6;
  localparam int LANE_FIELD_W = 3;

  // Saturation limits of a 16-bit result part
  localparam int SAT_POS     = 32767;
  localparam int SAT_NEG_MAG = 32768;

  // Operation codes
  localparam logic OP_COEF = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Input request
  typedef struct packed {
    logic                     operation;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_re;
    logic signed [COEF_W-1:0] coef_im;
    logic signed [SMP_W-1:0]  sample_re;
    logic signed [SMP_W-1:0]  sample_im;
    logic signed [CAS_W-1:0]  cascade_re;
    logic signed [CAS_W-1:0]  cascade_im;
  } cbmvm_in_t;

  // Lane result
  typedef struct packed {
    logic signed [OUT_W-1:0]  out_re;
    logic signed [OUT_W-1:0]  out_im;
    logic [LANE_FIELD_W-1:0]  lane;
    logic                     last;
  } cbmvm_out_t;

  // Control from the sequencer to every lane cell
  typedef struct packed {
    logic coef_wr;
    logic mul_en;
    logic acc_en;
    logic shift_en;
  } cbmvm_cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/cbmvm_cell.sv
`default_nettype none
module cbmvm_cell #(
  parameter int LANES     = cbmvm_pkg::LANES_DEF,
  parameter int ACC_WIDTH = cbmvm_pkg::ACC_W_DEF,
  parameter int LANE_IDX  = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cbmvm_pkg::cbmvm_cell_ctrl_t          ctrl_i,
  input  logic [cbmvm_pkg::IDX_W-1:0]          coef_index_i,
  input  logic signed [cbmvm_pkg::COEF_W-1:0]  coef_re_i,
  input  logic signed [cbmvm_pkg::COEF_W-1:0]  coef_im_i,
  input  logic [$clog2(LANES)-1:0]             row_i,
  input  logic signed [cbmvm_pkg::SMP_W-1:0]   sample_re_i,
  input  logic signed [cbmvm_pkg::SMP_W-1:0]   sample_im_i,
  input  logic [$clog2(LANES)-1:0]             acc_row_i,
  input  logic [ACC_WIDTH-1:0]                 cas_re_i,
  input  logic [ACC_WIDTH-1:0]                 cas_im_i,
  input  logic [ACC_WIDTH-1:0]                 nbr_re_i,
  input  logic [ACC_WIDTH-1:0]                 nbr_im_i,
  output logic [ACC_WIDTH-1:0]                 acc_re_o,
  output logic [ACC_WIDTH-1:0]                 acc_im_o
);

  localparam int LW     = $clog2(LANES);
  localparam int NCOEF  = LANES * LANES;
  localparam int NIDX   = 2 ** cbmvm_pkg::IDX_W;
  localparam int PROD_W = 2 * cbmvm_pkg::COEF_W;

  logic [LANES-1:0] row_wr;

  // Slot decode: index wraps modulo the store size
  for (genvar k = 0; k < LANES; k++) begin : g_row
    logic [NIDX-1:0] match;
    for (genvar j = 0; j < NIDX; j++) begin : g_idx
      localparam int JM = j % NCOEF;
      assign match[j] = (JM == k * LANES + LANE_IDX) &&
                        (coef_index_i == cbmvm_pkg::IDX_W'(j));
    end
    assign row_wr[k] = ctrl_i.coef_wr && (|match);
  end

  // Coefficient column of this lane, one entry per sample index
  logic signed [cbmvm_pkg::COEF_W-1:0] cre_q [LANES];
  logic signed [cbmvm_pkg::COEF_W-1:0] cim_q [LANES];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      if (row_wr[k]) begin
        cre_q[k] <= coef_re_i;
        cim_q[k] <= coef_im_i;
      end
    end
  end

  logic signed [cbmvm_pkg::COEF_W-1:0] cr, ci;
  assign cr = cre_q[row_i];
  assign ci = cim_q[row_i];

  // Partial products, registered
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p_rr_q <= sample_re_i * cr;
      p_ii_q <= sample_im_i * ci;
      p_ri_q <= sample_re_i * ci;
      p_ir_q <= sample_im_i * cr;
    end
  end

  // Complex product folded to accumulator width
  logic signed [PROD_W:0] pr_full, pi_full;
  logic signed [63:0]     pr64, pi64;
  logic [ACC_WIDTH-1:0]   pr_acc, pi_acc;
  logic                   cas_sel;

  assign pr_full = (PROD_W+1)'(p_rr_q) - (PROD_W+1)'(p_ii_q);
  assign pi_full = (PROD_W+1)'(p_ri_q) + (PROD_W+1)'(p_ir_q);
  assign pr64    = 64'(pr_full);
  assign pi64    = 64'(pi_full);
  assign pr_acc  = pr64[ACC_WIDTH-1:0];
  assign pi_acc  = pi64[ACC_WIDTH-1:0];
  assign cas_sel = (acc_row_i == LW'(LANE_IDX));

  // Accumulator; during drain it takes the neighbour's value
  logic [ACC_WIDTH-1:0] acc_re_q, acc_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctrl_i.shift_en) begin
      acc_re_q <= nbr_re_i;
      acc_im_q <= nbr_im_i;
    end else if (ctrl_i.acc_en) begin
      acc_re_q <= acc_re_q + pr_acc + (cas_sel ? cas_re_i : '0);
      acc_im_q <= acc_im_q + pi_acc + (cas_sel ? cas_im_i : '0);
    end
  end

  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule
`default_nettype wire

>>> rtl/cbmvm_finish.sv
`default_nettype none
module cbmvm_finish #(
  parameter int ACC_WIDTH = cbmvm_pkg::ACC_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_v_i,
  input  logic [ACC_WIDTH-1:0]                acc_re_i,
  input  logic [ACC_WIDTH-1:0]                acc_im_i,
  input  logic [cbmvm_pkg::LANE_FIELD_W-1:0]  lane_i,
  input  logic                                last_i,
  input  logic [cbmvm_pkg::SHIFT_W-1:0]       shift_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cbmvm_pkg::cbmvm_out_t               out_data_o
);

  localparam int SW = ACC_WIDTH + 1;
  localparam int OW = cbmvm_pkg::OUT_W;

  logic en;
  assign en      = !out_valid_o || !out_stall_i;
  assign ready_o = en;

  logic [ACC_WIDTH-1:0] acc_in [2];
  assign acc_in[0] = acc_re_i;
  assign acc_in[1] = acc_im_i;

  // Stage A: sign and magnitude
  logic                 a_v_q;
  logic [ACC_WIDTH-1:0] a_mag_q [2];
  logic                 a_neg_q [2];
  logic [cbmvm_pkg::LANE_FIELD_W-1:0] a_lane_q, b_lane_q;
  logic                 a_last_q, b_last_q;

  // Stage B: rounding term added
  logic                 b_v_q;
  logic [SW-1:0]        b_sum_q [2];
  logic                 b_neg_q [2];

  logic [SW-1:0]        rnd;
  assign rnd = (shift_i == '0) ? '0 :
               (SW'(1) << (shift_i - cbmvm_pkg::SHIFT_W'(1)));

  // Stage C: shift and saturate
  logic [SW-1:0]        shifted [2];
  logic [SW-1:0]        negated [2];
  logic [OW-1:0]        res     [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      shifted[p] = b_sum_q[p] >> shift_i;
      negated[p] = '0 - shifted[p];
      if (b_neg_q[p]) begin
        res[p] = (shifted[p] > SW'(cbmvm_pkg::SAT_NEG_MAG)) ?
                 OW'(-cbmvm_pkg::SAT_NEG_MAG) : negated[p][OW-1:0];
      end else begin
        res[p] = (shifted[p] > SW'(cbmvm_pkg::SAT_POS)) ?
                 OW'(cbmvm_pkg::SAT_POS) : shifted[p][OW-1:0];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      a_v_q       <= in_v_i;
      b_v_q       <= a_v_q;
      out_valid_o <= b_v_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 2; p++) begin
        a_neg_q[p] <= acc_in[p][ACC_WIDTH-1];
        a_mag_q[p] <= acc_in[p][ACC_WIDTH-1] ? ('0 - acc_in[p]) : acc_in[p];
        b_neg_q[p] <= a_neg_q[p];
        b_sum_q[p] <= SW'(a_mag_q[p]) + rnd;
      end
      a_lane_q          <= lane_i;
      a_last_q          <= last_i;
      b_lane_q          <= a_lane_q;
      b_last_q          <= a_last_q;
      out_data_o.out_re <= res[0];
      out_data_o.out_im <= res[1];
      out_data_o.lane   <= b_lane_q;
      out_data_o.last   <= b_last_q;
    end
  end

endmodule
`default_nettype wire

>>> rtl/complex_beamform_mvm_8x8.sv
// Complex 8x8 beamforming matrix-vector stage.
// Input channel (in_valid_i / in_stall_o, payload cbmvm_in_t): a request with
// operation OP_COEF writes one coefficient into the lane cells; OP_DATA brings
// sample k and the cascade partial for lane k. Requests are taken one per
// cycle while a vector is being accumulated.
// After the LANES-th sample the input stalls: the sequencer waits in FLUSH
// until the multiply/accumulate pipe has emptied, then in DRAIN the
// accumulators shift down the row of cells into the rounding unit, one lane
// per cycle (longer while the output is stalled). The input reopens once the
// last lane has entered the rounding unit; each result passes its stages A, B
// and C, and results follow one per cycle unless the output is stalled.
// Output channel (out_valid_o / out_stall_i, payload cbmvm_out_t): lanes come
// in order 0..LANES-1, last marks the final lane; a stalled result holds and
// the drain waits on it.
// Config channel (cfg_valid_i / cfg_ready_o): always ready, sets shift amount.
// Reset clears the accumulators, counters and shift amount; coefficients are
// not cleared and must be written before use.
`default_nettype none
module complex_beamform_mvm_8x8 #(
  parameter int LANES     = cbmvm_pkg::LANES_DEF,
  parameter int ACC_WIDTH = cbmvm_pkg::ACC_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cbmvm_pkg::cbmvm_in_t           in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cbmvm_pkg::cbmvm_out_t          out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cbmvm_pkg::SHIFT_W-1:0]  cfg_data_i
);

  localparam int LW = $clog2(LANES);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Shift amount register
  logic [cbmvm_pkg::SHIFT_W-1:0] shift_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      shift_q <= cfg_data_i;
    end
  end

  // Sequencer
  logic [1:0]    state_q, state_d;
  logic [LW-1:0] cnt_q, dcnt_q;
  logic          in_acc, in_data, drain_go, fin_ready;
  logic          s1_v_q, s2_v_q;

  assign in_stall_o = (state_q != ST_RUN);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_data    = in_acc && (in_data_i.operation == cbmvm_pkg::OP_DATA);
  assign drain_go   = (state_q == ST_DRAIN) && fin_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (in_data && (cnt_q == LW'(LANES - 1))) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!s1_v_q && !s2_v_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_go && (dcnt_q == LW'(LANES - 1))) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_data) begin
        cnt_q <= (cnt_q == LW'(LANES - 1)) ? '0 : cnt_q + LW'(1);
      end
      if (drain_go) begin
        dcnt_q <= (dcnt_q == LW'(LANES - 1)) ? '0 : dcnt_q + LW'(1);
      end
    end
  end

  // Stage 1: registered request; stage 2: cascade and row for accumulation
  cbmvm_pkg::cbmvm_in_t s1_q;
  logic [LW-1:0]        k1_q, k2_q;
  logic [ACC_WIDTH-1:0] cas_re_q, cas_im_q;
  logic signed [63:0]   cas_re64, cas_im64;
  logic                 s1_data;

  assign s1_data  = s1_v_q && (s1_q.operation == cbmvm_pkg::OP_DATA);
  assign cas_re64 = 64'(s1_q.cascade_re);
  assign cas_im64 = 64'(s1_q.cascade_im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_acc;
      s2_v_q <= s1_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
      k1_q <= cnt_q;
    end
    if (s1_data) begin
      k2_q     <= k1_q;
      cas_re_q <= cas_re64[ACC_WIDTH-1:0];
      cas_im_q <= cas_im64[ACC_WIDTH-1:0];
    end
  end

  cbmvm_pkg::cbmvm_cell_ctrl_t ctrl;
  assign ctrl.coef_wr  = s1_v_q && (s1_q.operation == cbmvm_pkg::OP_COEF);
  assign ctrl.mul_en   = s1_data;
  assign ctrl.acc_en   = s2_v_q;
  assign ctrl.shift_en = drain_go;

  // Row of lane cells; accumulators drain towards cell 0
  logic [ACC_WIDTH-1:0] chain_re [LANES+1];
  logic [ACC_WIDTH-1:0] chain_im [LANES+1];
  assign chain_re[LANES] = '0;
  assign chain_im[LANES] = '0;

  for (genvar l = 0; l < LANES; l++) begin : g_cell
    cbmvm_cell #(
      .LANES     (LANES),
      .ACC_WIDTH (ACC_WIDTH),
      .LANE_IDX  (l)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .coef_index_i (s1_q.coef_index),
      .coef_re_i    (s1_q.coef_re),
      .coef_im_i    (s1_q.coef_im),
      .row_i        (k1_q),
      .sample_re_i  (s1_q.sample_re),
      .sample_im_i  (s1_q.sample_im),
      .acc_row_i    (k2_q),
      .cas_re_i     (cas_re_q),
      .cas_im_i     (cas_im_q),
      .nbr_re_i     (chain_re[l+1]),
      .nbr_im_i     (chain_im[l+1]),
      .acc_re_o     (chain_re[l]),
      .acc_im_o     (chain_im[l])
    );
  end

  // Shift, round and saturate
  cbmvm_finish #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_v_i      (state_q == ST_DRAIN),
    .acc_re_i    (chain_re[0]),
    .acc_im_i    (chain_im[0]),
    .lane_i      (cbmvm_pkg::LANE_FIELD_W'(dcnt_q)),
    .last_i      (dcnt_q == LW'(LANES - 1)),
    .shift_i     (shift_q),
    .ready_o     (fin_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> rtl/cbmvm_checker.sv
`default_nettype none
module cbmvm_checker #(
  parameter int LANES = cbmvm_pkg::LANES_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input cbmvm_pkg::cbmvm_in_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input cbmvm_pkg::cbmvm_out_t out_data_o
);

  // A stalled result stays and holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Input only closes right after a data request was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o &&
                                in_data_i.operation == cbmvm_pkg::OP_DATA))
    else $error("input stalled without a closing sample");

  // Flush keeps the input closed past the cycle in which it closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |=> in_stall_o)
    else $error("input reopened before the vector was drained");

  // The final result of a vector belongs to the top lane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      out_data_o.lane == cbmvm_pkg::LANE_FIELD_W'(LANES - 1))
    else $error("last flag on wrong lane");

endmodule

bind complex_beamform_mvm_8x8 cbmvm_checker #(
  .LANES (LANES)
) u_cbmvm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
